@@ hw/rtl/bgpw_pkg.sv @@
// ----------------------------------------------------------------------------
// bgpw_pkg
// Shared types, register indexes and the 8x8 font table of the glyph writer.
// ----------------------------------------------------------------------------
package bgpw_pkg;

    localparam int GLYPH_SIZE = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_BYTES    = 3'd4;

    typedef struct packed {
        logic [11:0] x_offset;
        logic [11:0] y_offset;
        logic [2:0]  bytes_per_pixel;
        logic [15:0] line_stride;
        logic [25:0] screen_bytes;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_FLUSH
    } t_state;

    // Row 0 of each glyph sits in the top byte of the packed word.
    function automatic logic [7:0] glyph_row(input logic [7:0] code, input logic [2:0] row);
        logic [63:0] rows;
        logic [2:0]  idx;
        case (code)
            8'h61:   rows = 64'h00_00_3C_06_3E_66_3E_00;
            8'h62:   rows = 64'h00_60_60_7C_66_66_7C_00;
            8'h63:   rows = 64'h00_00_3C_66_60_66_3C_00;
            8'h64:   rows = 64'h00_06_06_3E_66_66_3E_00;
            8'h65:   rows = 64'h00_00_3C_66_7E_60_3C_00;
            8'h66:   rows = 64'h00_0E_18_3E_18_18_18_00;
            8'h67:   rows = 64'h00_00_3E_66_66_3E_06_7C;
            8'h68:   rows = 64'h00_60_60_7C_66_66_66_00;
            8'h69:   rows = 64'h00_00_3C_0C_0C_0C_3C_00;
            8'h6A:   rows = 64'h00_06_06_06_06_66_66_3C;
            8'h6B:   rows = 64'h00_60_66_6C_78_6C_66_00;
            8'h6C:   rows = 64'h00_38_18_18_18_18_3C_00;
            8'h6D:   rows = 64'h00_00_66_7E_7E_6E_67_00;
            8'h6E:   rows = 64'h00_00_7C_66_66_66_66_00;
            8'h6F:   rows = 64'h00_00_3C_66_66_66_3C_00;
            8'h70:   rows = 64'h00_00_7C_66_66_7C_60_60;
            8'h71:   rows = 64'h00_00_3C_6C_6C_3C_0D_0F;
            8'h72:   rows = 64'h00_00_7C_66_66_7C_66_00;
            8'h73:   rows = 64'h00_00_3E_40_3C_02_7C_00;
            8'h74:   rows = 64'h00_18_18_7E_18_18_18_00;
            8'h75:   rows = 64'h00_00_66_66_66_66_3E_00;
            8'h76:   rows = 64'h00_00_66_66_66_3C_18_00;
            8'h77:   rows = 64'h00_00_63_6B_6B_3E_36_00;
            8'h78:   rows = 64'h00_00_66_3C_18_3C_66_00;
            8'h79:   rows = 64'h00_00_66_66_66_3E_06_3C;
            8'h7A:   rows = 64'h00_00_7E_0C_18_30_7E_00;
            default: rows = 64'h0;
        endcase
        idx = ~row;
        return rows[{idx, 3'b000} +: 8];
    endfunction

endpackage

@@ hw/rtl/bgpw_ram.sv @@
// ----------------------------------------------------------------------------
// bgpw_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bgpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bgpw_font_rom.sv @@
// ----------------------------------------------------------------------------
// bgpw_font_rom
// Font memory, loaded from the package table by a sweep after reset.
// ----------------------------------------------------------------------------
module bgpw_font_rom
    import bgpw_pkg::*;
#(
    parameter int CHAR_COUNT = 128
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_rd_en,
    input  logic [$clog2(CHAR_COUNT*GLYPH_SIZE)-1:0]      i_rd_addr,
    output logic [GLYPH_SIZE-1:0]                         o_rd_data,
    output logic                                          o_loaded
);

    localparam int DEPTH = CHAR_COUNT * GLYPH_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(GLYPH_SIZE);

    logic [AW:0]   r_fill_cnt;
    logic [AW:0]   n_fill_cnt;
    logic          loading;
    logic [7:0]    fill_code;
    logic [7:0]    fill_data;

    assign loading   = (r_fill_cnt != (AW+1)'(DEPTH));
    assign n_fill_cnt = r_fill_cnt + 1'b1;
    assign fill_code = 8'(r_fill_cnt[AW-1:RW]);
    assign fill_data = glyph_row(fill_code, r_fill_cnt[RW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cnt <= '0;
        end else if (loading) begin
            r_fill_cnt <= n_fill_cnt;
        end
    end

    bgpw_ram #(
        .WIDTH (GLYPH_SIZE),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (loading),
        .i_waddr (r_fill_cnt[AW-1:0]),
        .i_wdata (fill_data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (o_rd_data)
    );

    assign o_loaded = !loading;

endmodule

@@ hw/rtl/bgpw_cfg.sv @@
// ----------------------------------------------------------------------------
// bgpw_cfg
// Configuration register file: offsets, pixel size, stride and screen size.
// ----------------------------------------------------------------------------
module bgpw_cfg
    import bgpw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_offset        <= '0;
            r_cfg.y_offset        <= '0;
            r_cfg.bytes_per_pixel <= 3'd4;
            r_cfg.line_stride     <= '0;
            r_cfg.screen_bytes    <= '0;
        end else if (i_wr_en) begin
            unique case (i_index)
                CFG_X_OFFSET:        r_cfg.x_offset        <= i_data[11:0];
                CFG_Y_OFFSET:        r_cfg.y_offset        <= i_data[11:0];
                CFG_BYTES_PER_PIXEL: r_cfg.bytes_per_pixel <= i_data[2:0];
                CFG_LINE_STRIDE:     r_cfg.line_stride     <= i_data[15:0];
                CFG_SCREEN_BYTES:    r_cfg.screen_bytes    <= i_data[25:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/bitmap_glyph_pixel_writer_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_glyph_pixel_writer_unit
// Expands one character request into framebuffer pixel writes from an 8x8 font.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | content
//  ---------+-----------+---------------------------+------------------------------
//  s_axis   | in        | tvalid/tready             | code, start x/y, colour
//  m_axis   | out       | tvalid/tready, tlast      | byte address, colour
//  cfg      | in        | valid/ready (always ready)| register index and data
//
//  After reset the font memory is loaded by a sweep over every row of the font
//  table; no request is taken until it ends.
//  A drawable request scans the 64 glyph pixels, one glyph pixel per cycle
//  while the output does not stall, through the font memory read and the
//  address adder, then passes the tail and flush states; codes at or above
//  CHAR_COUNT are accepted and dropped without output.
//  A stalled output holds the scan whenever a second found pixel waits.
//  Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module bitmap_glyph_pixel_writer_unit
    import bgpw_pkg::*;
#(
    parameter int CHAR_COUNT = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // char_code[7:0], start_x[19:8], start_y[31:20], pixel_color[63:32]
    input  logic [63:0]           i_s_axis_tdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // byte_address[25:0], write_color[57:26], zero fill[63:58]
    output logic [63:0]           o_m_axis_tdata,
    output logic                  o_m_axis_tvalid,
    output logic                  o_m_axis_tlast,
    input  logic                  i_m_axis_tready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(CHAR_COUNT);
    localparam int AW = $clog2(CHAR_COUNT * GLYPH_SIZE);
    localparam logic [8:0] CODE_LIMIT = 9'(CHAR_COUNT);

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;

    logic        loaded;
    logic [7:0]  rd_data;
    logic        s_accept;
    logic        code_ok;
    logic        scan_active;
    logic        flushing;
    logic        s0_fire;
    logic        advance;
    logic        out_free;
    logic        cand;
    logic        push;
    logic [12:0] in_xbase;
    logic [12:0] in_ybase;
    logic [13:0] xsum;
    logic [13:0] ysum;
    logic [30:0] addr_sum;

    logic [CW-1:0] r_code;
    logic [12:0]   r_xbase;
    logic [12:0]   r_ybase;
    logic [31:0]   r_color;
    logic [5:0]    r_pix;

    logic          r_s1_valid;
    logic [2:0]    r_s1_col;
    logic [16:0]   r_s1_xterm;
    logic [29:0]   r_s1_yterm;

    logic          r_hold_valid;
    logic [25:0]   r_hold_addr;

    logic          r_out_valid;
    logic          r_out_last;
    logic [25:0]   r_out_addr;
    logic [31:0]   r_out_color;

    bgpw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bgpw_font_rom #(
        .CHAR_COUNT (CHAR_COUNT)
    ) u_font (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s0_fire),
        .i_rd_addr ({r_code, r_pix[5:3]}),
        .o_rd_data (rd_data),
        .o_loaded  (loaded)
    );

    assign o_cfg_ready = 1'b1;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign code_ok  = ({1'b0, i_s_axis_tdata[7:0]} < CODE_LIMIT);
    assign in_xbase = 13'(i_s_axis_tdata[19:8]) + 13'(cfg.x_offset);
    assign in_ybase = 13'(i_s_axis_tdata[31:20]) + 13'(cfg.y_offset);

    // Candidate pixel of stage 1: glyph bit set and address on screen.
    assign addr_sum = 31'(r_s1_xterm) + 31'(r_s1_yterm);
    assign cand     = r_s1_valid && rd_data[~r_s1_col]
                      && (addr_sum < 31'(cfg.screen_bytes));
    assign out_free = !r_out_valid || i_m_axis_tready;

    // A found pixel only stalls when one is already held and the output is full.
    assign advance = !(cand && r_hold_valid && !out_free);
    assign s0_fire = scan_active && advance;
    assign push    = (advance && cand && r_hold_valid)
                     || (flushing && r_hold_valid && out_free);

    assign xsum = 14'(r_xbase) + 14'(r_pix[2:0]);
    assign ysum = 14'(r_ybase) + 14'(r_pix[5:3]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (loaded) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept && code_ok) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (s0_fire && (r_pix == 6'd63)) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (advance) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_hold_valid || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        scan_active     = 1'b0;
        flushing        = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_s_axis_tready = 1'b1;
            ST_SCAN:  scan_active     = 1'b1;
            ST_FLUSH: flushing        = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_FILL;
            r_pix        <= '0;
            r_s1_valid   <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_accept) begin
                r_pix <= '0;
            end else if (s0_fire) begin
                r_pix <= r_pix + 1'b1;
            end
            if (advance) begin
                r_s1_valid <= s0_fire;
            end
            if (advance && cand) begin
                r_hold_valid <= 1'b1;
            end else if (flushing && out_free) begin
                r_hold_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_code  <= CW'(i_s_axis_tdata[7:0]);
            r_xbase <= in_xbase;
            r_ybase <= in_ybase;
            r_color <= i_s_axis_tdata[63:32];
        end
        if (s0_fire) begin
            r_s1_col   <= r_pix[2:0];
            r_s1_xterm <= 17'(xsum) * 17'(cfg.bytes_per_pixel);
            r_s1_yterm <= 30'(ysum) * 30'(cfg.line_stride);
        end
        if (advance && cand) begin
            r_hold_addr <= addr_sum[25:0];
        end
        if (push) begin
            r_out_addr  <= r_hold_addr;
            r_out_color <= r_color;
            r_out_last  <= flushing;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {6'b0, r_out_color, r_out_addr};

endmodule
